// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the centroid unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Types, widths and helper functions of the foreground pixel centroid unit.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 8;
  localparam int DIM_W     = 13;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int PIX_W     = 32;
  localparam int SUM_W     = 37;
  localparam int CNT_W     = 25;
  localparam int DVD_W     = SUM_W + FRAC_BITS;
  localparam int QUOT_W    = IDX_W + FRAC_BITS;
  localparam int REM_W     = DVD_W - QUOT_W;
  localparam int ITER_W    = $clog2(QUOT_W);
  localparam int OFF_W     = 20;
  localparam int CTR_W     = IDX_W + FRAC_BITS - 1;
  localparam int OUT_W     = 72;
  localparam int ADDR_W    = 4;

  localparam logic [7:0] ALPHA_LIMIT = 8'd127;

  localparam logic [1:0] REG_BG     = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic signed [OFF_W:0] OFF_MAX_EXT = (OFF_W+1)'(524287);
  localparam logic signed [OFF_W:0] OFF_MIN_EXT = -(OFF_W+1)'(524288);

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
    logic             last;
  } acc_status_t;

  typedef enum logic [4:0] {
    S_ACC   = 5'b00001,
    S_KICKX = 5'b00010,
    S_WAITX = 5'b00100,
    S_WAITY = 5'b01000,
    S_LOAD  = 5'b10000
  } fpc_state_t;

  // Dimension minus one, with zero acting as one and values above MAX_DIM clamped.
  function automatic logic [IDX_W-1:0] dim_minus_one(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - DIM_W'(1));
    end
    return r;
  endfunction

  // Mean minus the image centre, saturated to the signed output range.
  function automatic logic [OFF_W-1:0] sat_offset(input logic [QUOT_W-1:0] mean,
                                                  input logic [IDX_W-1:0] dm1);
    logic [CTR_W-1:0]        centre;
    logic signed [OFF_W:0]   diff;
    logic [OFF_W-1:0]        r;
    centre = {dm1, {(FRAC_BITS-1){1'b0}}};
    diff = $signed({{(OFF_W+1-QUOT_W){1'b0}}, mean})
         - $signed({{(OFF_W+1-CTR_W){1'b0}}, centre});
    if (diff > OFF_MAX_EXT) begin
      r = OFF_MAX_EXT[OFF_W-1:0];
    end else if (diff < OFF_MIN_EXT) begin
      r = OFF_MIN_EXT[OFF_W-1:0];
    end else begin
      r = diff[OFF_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/fpc_accum.sv =====
// ----------------------------------------------------------------------------
// fpc_accum
// Pixel classifier, coordinate counters and coordinate sums of one frame.
// ----------------------------------------------------------------------------
module fpc_accum import fpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  input  logic [PIX_W-1:0] bg_colour,
  input  logic [IDX_W-1:0] wm1,
  input  logic [IDX_W-1:0] hm1,
  input  logic             clear,
  output acc_status_t      status
);

  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             fg;
  logic             row_end;
  logic             col_end;

  assign fg      = (pixel[PIX_W-1 -: 8] >= ALPHA_LIMIT) && (pixel != bg_colour);
  assign row_end = row_r >= hm1;
  assign col_end = col_r >= wm1;

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    count_nxt = count_r;
    if (clear) begin
      sum_x_nxt = '0;
      sum_y_nxt = '0;
      count_nxt = '0;
    end else if (accept) begin
      if (fg) begin
        sum_x_nxt = sum_x_r + SUM_W'(col_r);
        sum_y_nxt = sum_y_r + SUM_W'(row_r);
        count_nxt = count_r + CNT_W'(1);
      end
      if (row_end) begin
        row_nxt = '0;
        col_nxt = col_end ? '0 : col_r + IDX_W'(1);
      end else begin
        row_nxt = row_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      count_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      count_r <= count_nxt;
    end
  end

  assign status.sum_x = sum_x_r;
  assign status.sum_y = sum_y_r;
  assign status.count = count_r;
  assign status.last  = row_end && col_end;

endmodule

// ===== rtl/fpc_div.sv =====
// ----------------------------------------------------------------------------
// fpc_div
// Restoring divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
module fpc_div import fpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic              zero_r, zero_nxt;
  logic [REM_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, q_r[QUOT_W-1]};
  assign ge    = trial >= (REM_W+1)'(dsr_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = ITER_W'(QUOT_W - 1);
      rem_nxt  = dividend[DVD_W-1:QUOT_W];
      q_nxt    = dividend[QUOT_W-1:0];
      dsr_nxt  = divisor;
      zero_nxt = divisor == '0;
    end else if (busy_r) begin
      rem_nxt = ge ? REM_W'(trial - (REM_W+1)'(dsr_r)) : trial[REM_W-1:0];
      q_nxt   = {q_r[QUOT_W-2:0], ge};
      if (iter_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        iter_nxt = iter_r - ITER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dsr_r  <= dsr_nxt;
    zero_r <= zero_nxt;
  end

  assign done     = done_r;
  assign quotient = zero_r ? '0 : q_r;

endmodule

// ===== rtl/foreground_pixel_centroid_unit.sv =====
// ----------------------------------------------------------------------------
// foreground_pixel_centroid_unit
// Centroid of the foreground pixels of a column-major ARGB frame.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream, one per transaction, x as the outer loop.
// While a frame streams in, in_tready stays high and one pixel is taken per
// cycle whenever in_tvalid is high. After the last pixel of a frame, in_tready
// drops: the single shared restoring divider works out the x mean and then
// the y mean, one quotient bit per cycle. The result then sits in the output
// register as one out_ transaction and in_tready rises again, so the next
// frame may stream in while the result waits. If the receiver still stalls
// when the next frame ends, the block holds in_tready low until the earlier
// result is taken. Reset clears the frame counters and sums, drops out_tvalid
// and restores the registers: background 0, width and height 4096. Registers
// are written over the cfg_ port, which never waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module foreground_pixel_centroid_unit import fpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,     // [31:0] pixel_argb
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,    // [19:0] offset_x, [39:20] offset_y,
                                          // [64:40] point_count, rest zero
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  fpc_state_t        state_r, state_nxt;
  logic [PIX_W-1:0]  bg_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [IDX_W-1:0]  wm1;
  logic [IDX_W-1:0]  hm1;
  acc_status_t       acc_st;
  logic              in_accept;
  logic              cfg_wr;
  logic              acc_clear;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [QUOT_W-1:0] mean_x_r, mean_x_nxt;
  logic              out_free;
  logic              out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0]  off_x_r;
  logic [OFF_W-1:0]  off_y_r;
  logic [CNT_W-1:0]  cnt_out_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r     <= '0;
      width_r  <= DIM_W'(MAX_DIM);
      height_r <= DIM_W'(MAX_DIM);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_BG:     bg_r     <= cfg_pwdata;
        REG_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_BG:     cfg_prdata = bg_r;
      REG_WIDTH:  cfg_prdata = 32'(width_r);
      REG_HEIGHT: cfg_prdata = 32'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign wm1 = dim_minus_one(width_r);
  assign hm1 = dim_minus_one(height_r);

  assign in_tready = state_r == S_ACC;
  assign in_accept = in_tvalid && in_tready;

  fpc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .pixel     (in_tdata),
    .bg_colour (bg_r),
    .wm1       (wm1),
    .hm1       (hm1),
    .clear     (acc_clear),
    .status    (acc_st)
  );

  fpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (acc_st.count),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = {acc_st.sum_x, {FRAC_BITS{1'b0}}};
    acc_clear    = 1'b0;
    mean_x_nxt   = mean_x_r;
    unique case (state_r)
      S_ACC: begin
        if (in_accept && acc_st.last) begin
          state_nxt = S_KICKX;
        end
      end
      S_KICKX: begin
        div_start = 1'b1;
        state_nxt = S_WAITX;
      end
      S_WAITX: begin
        if (div_done) begin
          mean_x_nxt   = div_quot;
          div_dividend = {acc_st.sum_y, {FRAC_BITS{1'b0}}};
          div_start    = 1'b1;
          state_nxt    = S_WAITY;
        end
      end
      S_WAITY: begin
        if (div_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          acc_clear = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_LOAD && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mean_x_r <= mean_x_nxt;
    if (state_r == S_LOAD && out_free) begin
      off_x_r   <= sat_offset(mean_x_r, wm1);
      off_y_r   <= sat_offset(div_quot, hm1);
      cnt_out_r <= acc_st.count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-2*OFF_W-CNT_W){1'b0}}, cnt_out_r, off_y_r, off_x_r};

  `ASSERT_NEXT(a_frame_end_starts_divide, clk, rst_n,
               in_accept && acc_st.last, state_r == S_KICKX)
  `ASSERT_IMPLIES(a_done_only_while_waiting, clk, rst_n,
                  div_done, state_r == S_WAITX || state_r == S_WAITY)
  `ASSERT_NEXT(a_load_clears_sums, clk, rst_n,
               state_r == S_LOAD && out_free,
               out_tvalid && acc_st.count == '0 && in_tready)

endmodule

// ===== tb/sv/foreground_pixel_centroid_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foreground_pixel_centroid_unit_test
// Streams ARGB frames of many sizes and background settings into the centroid
// unit, predicts each frame's offsets and count, and scores every result.
// ----------------------------------------------------------------------------
module foreground_pixel_centroid_unit_test;
  import fpc_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESULT_LATENCY = 64;
  localparam int CYCLE_LIMIT    = 1500000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [OFF_W-1:0] offset_x;
    logic [OFF_W-1:0] offset_y;
    logic [CNT_W-1:0] count;
  } centroid_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata    = '0;   // [31:0] pixel_argb
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;          // [19:0] offset_x, [39:20] offset_y,
                                         // [64:40] point_count
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  logic [PIX_W-1:0]  bg_colour  = '0;
  logic [DIM_W-1:0]  width_reg  = DIM_W'(4096);
  logic [DIM_W-1:0]  height_reg = DIM_W'(4096);
  int unsigned       col_idx    = 0;
  int unsigned       row_idx    = 0;
  longint unsigned   x_total    = 0;
  longint unsigned   y_total    = 0;
  longint unsigned   fg_pixels  = 0;
  centroid_t         expected_centroids[$];

  int unsigned       gap_odds     = 0;
  int unsigned       stall_odds   = 0;
  int unsigned       error_count  = 0;
  int unsigned       results_seen = 0;
  int unsigned       cycle_count  = 0;

  foreground_pixel_centroid_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [OFF_W-1:0] centroid_offset(input longint unsigned total,
                                                       input longint unsigned n,
                                                       input int unsigned dim);
    longint mean;
    longint centre;
    longint off;
    mean = 0;
    centre = (longint'(dim - 1) << FRAC_BITS) >>> 1;
    if (n != 0) mean = longint'((total << FRAC_BITS) / n);
    off = mean - centre;
    if (off > 524287) off = 524287;
    if (off < -524288) off = -524288;
    return off[OFF_W-1:0];
  endfunction

  function automatic void advance_frame(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    bit          frame_done;
    centroid_t   c;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    frame_done = 1'b0;
    if (px[31:24] >= ALPHA_LIMIT && px != bg_colour) begin
      x_total += col_idx;
      y_total += row_idx;
      fg_pixels += 1;
    end
    if (row_idx + 1 >= h) begin
      row_idx = 0;
      if (col_idx + 1 >= w) frame_done = 1'b1;
      else col_idx += 1;
    end else begin
      row_idx += 1;
    end
    if (frame_done) begin
      c.offset_x = centroid_offset(x_total, fg_pixels, w);
      c.offset_y = centroid_offset(y_total, fg_pixels, h);
      c.count = (fg_pixels > longint'(2**CNT_W - 1)) ? {CNT_W{1'b1}} : CNT_W'(fg_pixels);
      expected_centroids.insert(expected_centroids.size(), c);
      col_idx = 0;
      row_idx = 0;
      x_total = 0;
      y_total = 0;
      fg_pixels = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) advance_frame(in_tdata);
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("result %0d %s: expected 0x%0h, actual 0x%0h",
                 results_seen, field, want, got);
    end
  endtask

  always @(posedge clk) begin : score_results
    centroid_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_centroids.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("result %0d arrived with no frame pending: 0x%0h",
                   results_seen, out_tdata);
      end else begin
        want = expected_centroids.pop_front();
        check_field("offset_x", 32'(want.offset_x), 32'(out_tdata[OFF_W-1:0]));
        check_field("offset_y", 32'(want.offset_y), 32'(out_tdata[2*OFF_W-1:OFF_W]));
        check_field("point_count", 32'(want.count),
                    32'(out_tdata[2*OFF_W+CNT_W-1:2*OFF_W]));
      end
    end
  end

  initial begin : drive_out_ready
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops the pixel stream, lets every pending frame result drain, then waits
  // out the divider latency so the block is quiet before registers change.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_centroids.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_BG:     bg_colour  = value;
      REG_WIDTH:  width_reg  = value[DIM_W-1:0];
      REG_HEIGHT: height_reg = value[DIM_W-1:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    write_reg(REG_WIDTH, ($urandom() & 32'hFFFF_E000) | 32'(w));
    write_reg(REG_HEIGHT, ($urandom() & 32'hFFFF_E000) | 32'(h));
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] px;
    px = $urandom();
    case ($urandom_range(0, 5))
      0: px = bg_colour;
      1: px[31:24] = 8'($urandom_range(0, 126));
      2: px[31:24] = 8'($urandom_range(127, 255));
      3: px[31:24] = 8'($urandom_range(126, 128));
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [PIX_W-1:0] clear_pixel();
    return {8'($urandom_range(0, 126)), 24'($urandom())};
  endfunction

  function automatic int unsigned random_dim();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 5);
  endfunction

  function automatic int unsigned random_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 8;
    endcase
  endfunction

  task automatic send_frames(input int unsigned frames);
    repeat (frames * clamp_dim(width_reg) * clamp_dim(height_reg)) send_pixel(random_pixel());
  endtask

  task automatic test_midframe_resize();
    gap_odds   = 4;
    stall_odds = 4;
    // At the reset size these pixels fill rows 0 to 4 of column 0; shrinking the
    // frame under them makes the next pixel close it.
    repeat (5) send_pixel(32'hFF00_0000 | 32'($urandom_range(1, 255)));
    settle_block();
    set_frame_size(1, 3);
    send_pixel(32'hFFFF_FFFF);
    settle_block();
    // The frame is narrowed under the columns already sent, so the next pixel
    // closes it.
    set_frame_size(4096, 1);
    for (int i = 0; i < 40; i++)
      send_pixel((i < 30) ? clear_pixel() : 32'hFF12_3456);
    settle_block();
    write_reg(REG_WIDTH, 32'd1);
    send_pixel(32'hFF65_4321);
    settle_block();
    set_frame_size(2, 40);
    repeat (40 + 25) send_pixel(random_pixel());
    settle_block();
    write_reg(REG_HEIGHT, 32'd20);
    send_pixel(random_pixel());
  endtask

  task automatic test_pixel_classes();
    logic [PIX_W-1:0] probes [25] = '{
      32'h80FF_00FF, 32'h80FF_00FE, 32'hFFFF_00FF, 32'h00FF_00FF, 32'h7EFF_FFFF,
      32'h7F00_0000, 32'h7FFF_FFFF, 32'h7E00_0000, 32'hFF00_0000, 32'hFFFF_FFFF,
      32'h0000_0000, 32'h00FF_FFFF, 32'h8000_0000, 32'h81FF_00FF, 32'h80FF_01FF,
      32'h807F_00FF, 32'hC0FF_00FF, 32'h0080_0000, 32'h7F7F_7F7F, 32'hA5A5_A5A5,
      32'h5A5A_5A5A, 32'hFE01_FE01, 32'h7FFF_00FF, 32'h80FF_00FF, 32'hFFFF_FFFE};
    settle_block();
    gap_odds   = 6;
    stall_odds = 6;
    write_reg(REG_BG, 32'h80FF_00FF);
    set_frame_size(5, 5);
    foreach (probes[i]) send_pixel(probes[i]);
    settle_block();
    // A frame without a single counted pixel reports the negated centre.
    set_frame_size(3, 2);
    repeat (3) begin
      send_pixel(bg_colour);
      send_pixel(clear_pixel());
    end
  endtask

  task automatic test_size_extremes();
    settle_block();
    stall_odds = 2;
    gap_odds   = 8;
    write_reg(REG_BG, 32'hFFFF_FFFF);
    set_frame_size(1, 1);
    send_frames(12);
    settle_block();
    stall_odds = 8;
    // A width above the limit acts as the limit, so these pixels stay in one
    // frame until the width is narrowed under them.
    set_frame_size(4097, 1);
    repeat (3) send_pixel(random_pixel());
    settle_block();
    write_reg(REG_WIDTH, 32'd2);
    send_pixel(random_pixel());
    settle_block();
    write_reg(REG_BG, 32'h0000_0000);
    set_frame_size(1, 4097);
    repeat (5) send_pixel(random_pixel());
    settle_block();
    write_reg(REG_HEIGHT, 32'd4);
    send_pixel(random_pixel());
    settle_block();
    set_frame_size(0, 3);
    send_frames(4);
    settle_block();
    write_reg(REG_BG, $urandom());
    set_frame_size(2, 2);
    send_frames(3);
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned frames;
    int unsigned n;
    sent   = 0;
    frames = 0;
    while (sent < 300 || frames < 20) begin
      settle_block();
      gap_odds   = random_odds();
      stall_odds = random_odds();
      if ($urandom_range(0, 2) != 0) write_reg(REG_BG, $urandom());
      set_frame_size(random_dim(), random_dim());
      n = $urandom_range(1, 4);
      send_frames(n);
      sent   += n * clamp_dim(width_reg) * clamp_dim(height_reg);
      frames += n;
    end
  endtask

  task automatic test_unstalled_tail();
    settle_block();
    gap_odds   = 0;
    stall_odds = 0;
    repeat (4) begin
      settle_block();
      set_frame_size(random_dim(), random_dim());
      send_frames($urandom_range(2, 4));
    end
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_midframe_resize();
    test_pixel_classes();
    test_size_extremes();
    test_random_frames();
    test_unstalled_tail();
    settle_block();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
